// ===== hw/rtl/bss_pkg.sv =====
// Shared constants, codes and types of the bright span segmenter.
package bss_pkg;

   // Stroke length limit and the index and count widths that follow from it.
   localparam int unsigned MAX_POINTS = 4096;
   localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
   localparam int unsigned CNT_W      = IDX_W + 1;

   // Field widths of the input words and the registers.
   localparam int unsigned LUM_W     = 16;
   localparam int unsigned GAP_W     = 4;
   localparam int unsigned CSR_IDX_W = 2;

   // Default depth of the span queue between the front and back parts.
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Register reset values.
   localparam logic [LUM_W-1:0] THRESHOLD_RESET = 16'd66;
   localparam logic [GAP_W-1:0] MAX_GAP_RESET   = 4'd3;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_MAX_GAP   = 2'd1
   } csr_index_type;

   // One emitted span.
   typedef struct packed {
      logic [IDX_W-1:0] start;
      logic [CNT_W-1:0] count;
      logic             final_of_item;
   } span_type;

   // Up to two spans written into the queue in one cycle.
   typedef struct packed {
      logic [1:0] push_cnt;
      span_type   span_a;
      span_type   span_b;
   } push_type;

   // Queue fill status seen by both sides.
   typedef struct packed {
      logic room;
      logic empty;
   } queue_status_type;

   // Stroke tracking state of the front part.
   typedef struct packed {
      logic [IDX_W-1:0] point_index;
      logic             span_open;
   } front_status_type;

endpackage

// ===== hw/rtl/bss_front.sv =====
// Front part: registers, point classification, span tracking and span generation.
module bss_front import bss_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [LUM_W-1:0]     req_luminance,
   input  logic                 req_stroke_end,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LUM_W-1:0]     csr_wdata,
   input  queue_status_type     q_status,
   output push_type             push,
   output front_status_type     f_status
);

   localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(MAX_POINTS - 1);

   logic [LUM_W-1:0] threshold_ff;
   logic [GAP_W-1:0] max_gap_ff;
   logic [IDX_W-1:0] point_index_ff, point_index_in;
   logic             span_open_ff, span_open_in;
   logic [IDX_W-1:0] open_start_ff, open_start_in;
   logic [IDX_W-1:0] last_bright_ff, last_bright_in;

   logic             accept;
   logic             bright;
   logic [IDX_W-1:0] gap_dist;
   logic             close_old;
   logic [IDX_W-1:0] pad_start;
   logic             start_new;
   logic             open_after;
   logic [IDX_W-1:0] start_after;
   logic [IDX_W-1:0] lb_after;
   logic [CNT_W-1:0] end0, end1;
   logic             emit0, emit1;
   span_type         span0, span1;

   // The configuration port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         max_gap_ff   <= MAX_GAP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_ff <= csr_wdata;
            CSR_MAX_GAP:   max_gap_ff   <= csr_wdata[GAP_W-1:0];
            default:       ;
         endcase
      end
   end

   // A point is taken only when the queue can hold two spans.
   assign req_ready = q_status.room;
   assign accept    = req_valid && q_status.room;

   // Classify the point and decide whether it closes the open span.
   always_comb begin
      bright    = req_luminance > threshold_ff;
      gap_dist  = point_index_ff - last_bright_ff;
      close_old = bright && span_open_ff
                  && (gap_dist > {{(IDX_W-GAP_W){1'b0}}, max_gap_ff});
      pad_start = (point_index_ff != '0) ? point_index_ff - 1'b1 : point_index_ff;
      start_new   = bright && (!span_open_ff || close_old);
      open_after  = span_open_ff || bright;
      start_after = start_new ? pad_start : open_start_ff;
      lb_after    = bright ? point_index_ff : last_bright_ff;
   end

   // The closed span is padded by one point after its last bright point.
   always_comb begin
      end0  = {1'b0, last_bright_ff} + CNT_W'(2);
      emit0 = close_old && (end0 > ({1'b0, open_start_ff} + CNT_W'(1)));
      span0.start         = open_start_ff;
      span0.count         = end0 - {1'b0, open_start_ff};
      span0.final_of_item = !emit1;
   end

   // At the stroke end the open span is padded only if a point follows it.
   always_comb begin
      end1 = (lb_after < point_index_ff) ? {1'b0, lb_after} + CNT_W'(2)
                                         : {1'b0, lb_after} + CNT_W'(1);
      emit1 = req_stroke_end && open_after
              && (end1 > ({1'b0, start_after} + CNT_W'(1)));
      span1.start         = start_after;
      span1.count         = end1 - {1'b0, start_after};
      span1.final_of_item = 1'b1;
   end

   // Pack the spans in emission order.
   always_comb begin
      push.push_cnt = accept ? (2'(emit0) + 2'(emit1)) : 2'd0;
      push.span_a   = emit0 ? span0 : span1;
      push.span_b   = span1;
   end

   // Next stroke state.
   always_comb begin
      point_index_in = point_index_ff;
      span_open_in   = span_open_ff;
      open_start_in  = open_start_ff;
      last_bright_in = last_bright_ff;
      if (accept) begin
         if (req_stroke_end) begin
            point_index_in = '0;
            span_open_in   = 1'b0;
            open_start_in  = '0;
            last_bright_in = '0;
         end else begin
            if (point_index_ff != LAST_INDEX) begin
               point_index_in = point_index_ff + 1'b1;
            end
            span_open_in   = open_after;
            open_start_in  = start_after;
            last_bright_in = lb_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         point_index_ff <= '0;
         span_open_ff   <= 1'b0;
         open_start_ff  <= '0;
         last_bright_ff <= '0;
      end else begin
         point_index_ff <= point_index_in;
         span_open_ff   <= span_open_in;
         open_start_ff  <= open_start_in;
         last_bright_ff <= last_bright_in;
      end
   end

   assign f_status.point_index = point_index_ff;
   assign f_status.span_open   = span_open_ff;

endmodule

// ===== hw/rtl/bss_queue.sv =====
// Span queue: takes up to two spans a cycle, gives one a cycle when popped.
module bss_queue import bss_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic             pop,
   output span_type         head,
   output queue_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned LVL_W = $clog2(DEPTH + 1);

   span_type         slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [PTR_W-1:0] wr_ptr2;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      if (ptr == PTR_W'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign wr_ptr2 = ptr_next(wr_ptr_ff);

   // Storage writes; the second span goes to the slot after the first.
   always_ff @(posedge clock) begin
      if (push.push_cnt != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.span_a;
      end
      if (push.push_cnt == 2'd2) begin
         slot_ff[wr_ptr2] <= push.span_b;
      end
   end

   // Pointer and fill level updates.
   always_comb begin
      case (push.push_cnt)
         2'd1:    wr_ptr_in = wr_ptr2;
         2'd2:    wr_ptr_in = ptr_next(wr_ptr2);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff + LVL_W'(push.push_cnt) - LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.room  = level_ff <= LVL_W'(DEPTH - 2);
   assign status.empty = level_ff == '0;

endmodule

// ===== hw/rtl/bss_back.sv =====
// Back part: moves spans from the queue into the output register.
module bss_back import bss_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  span_type         head,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [IDX_W-1:0] rsp_span_start,
   output logic [CNT_W-1:0] rsp_span_count,
   output logic             rsp_final_of_item
);

   logic     rsp_valid_ff, rsp_valid_in;
   span_type out_ff;

   // Load a new word whenever the register is empty or being taken.
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= head;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_span_start    = out_ff.start;
   assign rsp_span_count    = out_ff.count;
   assign rsp_final_of_item = out_ff.final_of_item;

endmodule

// ===== hw/rtl/bright_span_segmenter_core.sv =====
// Top level of the bright span segmenter: front part, span queue and back part.
//
// The block takes one stroke point per cycle while req_ready is high and
// finds spans of bright points (luminance above the threshold register,
// at most max_gap points apart), padded by one point on each side within
// the stroke. Each span of two or more points comes out as one word (start,
// count), the last word caused by a point carrying final_of_item. A point
// whose bright luminance closes one span and which also ends the stroke
// gives two words. Span words pass through the span queue into the output
// register. The output side drains one word per cycle while rsp_ready is
// high, and a point that gives two words is never followed by another such
// point, so with rsp_ready high the queue never holds more than two words
// while the input sustains one point per cycle. req_ready is low whenever
// fewer than two queue entries are free, which happens only while the output
// stalls. The configuration port takes a write in every cycle; the user
// must write it only while the block is idle, not enforced by the block.
module bright_span_segmenter_core import bss_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [LUM_W-1:0]     req_luminance,
   input  logic                 req_stroke_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [IDX_W-1:0]     rsp_span_start,
   output logic [CNT_W-1:0]     rsp_span_count,
   output logic                 rsp_final_of_item,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [LUM_W-1:0]     csr_wdata
);

   queue_status_type q_status;
   push_type         push;
   front_status_type f_status;
   span_type         head;
   logic             pop;

   bss_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_luminance  (req_luminance),
      .req_stroke_end (req_stroke_end),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_status       (q_status),
      .push           (push),
      .f_status       (f_status)
   );

   bss_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   bss_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .q_status          (q_status),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_span_start    (rsp_span_start),
      .rsp_span_count    (rsp_span_count),
      .rsp_final_of_item (rsp_final_of_item)
   );

`ifndef SYNTHESIS
   // After the last point of a stroke the tracking state starts over.
   a_stroke_restart: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_stroke_end)
      |=> (f_status.point_index == '0 && !f_status.span_open))
      else $error("stroke state not cleared after stroke end");

   // Two spans from one point happen only at the end of a stroke.
   a_double_at_end: assert property (@(posedge clock) disable iff (reset)
      (push.push_cnt == 2'd2) |-> req_stroke_end)
      else $error("two spans pushed without stroke end");

   // No more than two spans are ever pushed at once.
   a_push_limit: assert property (@(posedge clock) disable iff (reset)
      push.push_cnt != 2'd3)
      else $error("invalid span push count");

   // The back part reads only from a filled queue.
   a_pop_filled: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("span queue read while empty");
`endif

endmodule

// ===== tb/tb_bright_span_segmenter_core.sv =====
// Self-checking testbench of the bright span segmenter core.
module tb_bright_span_segmenter_core;
   import bss_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Register index that maps to no register; writes to it change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam span_type NO_SPAN = '0;

   // One row of the directed stimulus, with optional hand-written results.
   typedef struct packed {
      logic [LUM_W-1:0] lum;
      logic             last;
      logic             typed;
      logic [1:0]       n;
      span_type         a;
      span_type         b;
   } point_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [LUM_W-1:0]     req_luminance;
   logic                 req_stroke_end;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [IDX_W-1:0]     rsp_span_start;
   logic [CNT_W-1:0]     rsp_span_count;
   logic                 rsp_final_of_item;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LUM_W-1:0]     csr_wdata;

   // Register copies and stroke tracking state of the predictor.
   logic [LUM_W-1:0] bright_thr;
   logic [GAP_W-1:0] join_gap;
   logic [IDX_W-1:0] point_idx;
   logic             span_open;
   logic [IDX_W-1:0] open_start;
   logic [IDX_W-1:0] last_bright;
   span_type         found_spans [2];
   int               found_cnt;

   // Spans still to come out of the block, oldest first.
   span_type span_q [$];
   point_row_type rows [$];

   // Word currently offered on the input, with its hand-written results.
   logic     cur_typed;
   logic [1:0] cur_n;
   span_type cur_a;
   span_type cur_b;

   int send_idle_pct;
   int stall_pct;
   int errors;
   span_type got;
   span_type want;

   bright_span_segmenter_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_luminance     (req_luminance),
      .req_stroke_end    (req_stroke_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_span_start    (rsp_span_start),
      .rsp_span_count    (rsp_span_count),
      .rsp_final_of_item (rsp_final_of_item),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic span_type span_of(input int unsigned start, input int unsigned count,
                                        input logic fin);
      span_type s;
      s.start = start[IDX_W-1:0];
      s.count = count[CNT_W-1:0];
      s.final_of_item = fin;
      return s;
   endfunction

   // Add one row at the end of the directed table.
   function automatic void append_row(input point_row_type r);
      rows = {rows, r};
   endfunction

   // Record a span bounded by [start, end_excl) if it covers two or more points.
   function automatic void add_span(input int unsigned start, input int unsigned end_excl);
      if (end_excl > start && end_excl - start > 1) begin
         found_spans[found_cnt] = span_of(start, end_excl - start, 1'b0);
         found_cnt++;
      end
   endfunction

   // Advance the span tracker by one point and collect the spans it closes.
   function automatic void segment_point(input logic [LUM_W-1:0] lum, input logic last);
      int unsigned p;
      int unsigned end_excl;
      p = point_idx;
      found_cnt = 0;
      if (lum > bright_thr) begin
         // A bright point too far from the open span closes it, padded after.
         if (span_open && (p - last_bright) > join_gap) begin
            add_span(open_start, last_bright + 2);
            span_open = 1'b0;
         end
         if (!span_open) begin
            open_start = (p > 0) ? IDX_W'(p - 1) : '0;
            span_open = 1'b1;
         end
         last_bright = IDX_W'(p);
      end
      if (last) begin
         // No padding after when the last bright point ends the stroke.
         if (span_open) begin
            end_excl = (last_bright < p) ? last_bright + 2 : last_bright + 1;
            add_span(open_start, end_excl);
         end
         point_idx = '0;
         span_open = 1'b0;
         open_start = '0;
         last_bright = '0;
      end else if (point_idx < MAX_POINTS - 1) begin
         point_idx = point_idx + 1'b1;
      end
      if (found_cnt > 0)
         found_spans[found_cnt-1].final_of_item = 1'b1;
   endfunction

   // Checking of output words and prediction of accepted input words.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = span_of(rsp_span_start, rsp_span_count, rsp_final_of_item);
            if (span_q.size() == 0) begin
               if (errors < 10)
                  $display("unexpected span word: start %0d count %0d final %0b",
                           got.start, got.count, got.final_of_item);
               errors++;
            end else begin
               want = span_q.pop_front();
               if (got.start !== want.start || got.count !== want.count ||
                   got.final_of_item !== want.final_of_item) begin
                  if (errors < 10)
                     $display("span mismatch: expected start %0d count %0d final %0b, %s %0d %0d %0b",
                              want.start, want.count, want.final_of_item, "got",
                              got.start, got.count, got.final_of_item);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: bright_thr = csr_wdata;
               CSR_MAX_GAP:   join_gap = csr_wdata[GAP_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            segment_point(req_luminance, req_stroke_end);
            if (cur_typed) begin
               found_cnt = cur_n;
               found_spans[0] = cur_a;
               found_spans[1] = cur_b;
            end
            for (int k = 0; k < found_cnt; k++)
               span_q = {span_q, found_spans[k]};
         end
      end
   end

   // The receiver stalls at random at the rate of the current phase.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   // Offer one point after a random idle gap and hold it until it is taken.
   task automatic send_point(input logic [LUM_W-1:0] lum, input logic last,
                             input logic typed, input logic [1:0] n,
                             input span_type a, input span_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_luminance = lum;
      req_stroke_end = last;
      cur_typed = typed;
      cur_n = n;
      cur_a = a;
      cur_b = b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stop offering points and wait until every expected span has come out.
   task automatic settle();
      req_valid = 1'b0;
      while (span_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [LUM_W-1:0] data);
      settle();
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Luminance on either side of the threshold, biased to its edges.
   function automatic logic [LUM_W-1:0] pick_lum(input bit bright);
      int unsigned thr;
      int unsigned r;
      thr = bright_thr;
      r = $urandom_range(9);
      if (r == 0)
         return LUM_W'($urandom);
      if (bright && thr < 65535) begin
         if (r == 1)
            return LUM_W'(thr + 1);
         if (r == 2)
            return '1;
         return LUM_W'($urandom_range(65535, thr + 1));
      end
      if (r == 1)
         return '0;
      if (r == 2)
         return LUM_W'(thr);
      return LUM_W'($urandom_range(thr, 0));
   endfunction

   // Whole strokes whose dark runs cluster around the join distance.
   task automatic random_strokes(input int points);
      int sent;
      int len;
      int dark_left;
      bit bright;
      logic last;
      sent = 0;
      while (sent < points) begin
         len = ($urandom_range(7) == 0) ? $urandom_range(90, 30) : $urandom_range(20, 1);
         dark_left = $urandom_range(2);
         for (int i = 0; i < len; i++) begin
            bright = (dark_left == 0);
            if (bright)
               dark_left = $urandom_range(int'(join_gap) + 2, 0);
            else
               dark_left--;
            last = (i == len - 1) || ($urandom_range(63) == 0);
            send_point(pick_lum(bright), last, 1'b0, 2'd0, NO_SPAN, NO_SPAN);
            sent++;
            if (last)
               break;
         end
      end
   endtask

   task automatic run_phase(input logic [LUM_W-1:0] thr, input logic [LUM_W-1:0] gap_word,
                            input int sidle, input int stall, input int points);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_MAX_GAP, gap_word);
      send_idle_pct = sidle;
      stall_pct = stall;
      random_strokes(points);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_luminance = '0;
      req_stroke_end = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_THRESHOLD;
      csr_wdata = '0;
      cur_typed = 1'b0;
      cur_n = 2'd0;
      cur_a = NO_SPAN;
      cur_b = NO_SPAN;
      send_idle_pct = 10;
      stall_pct = 10;
      errors = 0;
      bright_thr = THRESHOLD_RESET;
      join_gap = MAX_GAP_RESET;
      point_idx = '0;
      span_open = 1'b0;
      open_start = '0;
      last_bright = '0;
      found_cnt = 0;

      // Directed strokes under the reset register values.
      // A lone bright point is a span of one and gives nothing.
      append_row(point_row_type'{16'hFFFF, 1'b1, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      // Luminance equal to the threshold is dark; padding after the last bright point.
      append_row(point_row_type'{16'd67, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      append_row(point_row_type'{16'd66, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      append_row(point_row_type'{16'd0, 1'b1, 1'b1, 2'd1, span_of(0, 2, 1), NO_SPAN});
      // A far bright point that also ends the stroke gives two words.
      append_row(point_row_type'{16'd100, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      repeat (4)
         append_row(point_row_type'{16'd0, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      append_row(point_row_type'{16'd200, 1'b1, 1'b1, 2'd2, span_of(0, 2, 0),
                                 span_of(4, 2, 1)});
      // Bright points exactly the join distance apart stay one span.
      append_row(point_row_type'{16'hFFFF, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      repeat (2)
         append_row(point_row_type'{16'd0, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      append_row(point_row_type'{16'hFFFF, 1'b1, 1'b1, 2'd1, span_of(0, 4, 1), NO_SPAN});
      // Padding before a span that starts inside the stroke.
      repeat (2)
         append_row(point_row_type'{16'd0, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      append_row(point_row_type'{16'd1000, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      append_row(point_row_type'{16'd0, 1'b1, 1'b1, 2'd1, span_of(1, 3, 1), NO_SPAN});
      // A dark stroke of one point.
      append_row(point_row_type'{16'd66, 1'b1, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      // A far bright point in mid stroke closes the span, the next one ends later.
      append_row(point_row_type'{16'd500, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      repeat (4)
         append_row(point_row_type'{16'd0, 1'b0, 1'b1, 2'd0, NO_SPAN, NO_SPAN});
      append_row(point_row_type'{16'd500, 1'b0, 1'b1, 2'd1, span_of(0, 2, 1), NO_SPAN});
      append_row(point_row_type'{16'd0, 1'b1, 1'b1, 2'd1, span_of(4, 3, 1), NO_SPAN});

      repeat (3) @(negedge clock);
      reset = 1'b0;

      foreach (rows[k])
         send_point(rows[k].lum, rows[k].last, rows[k].typed, rows[k].n, rows[k].a, rows[k].b);

      // Random strokes over several register settings and idling patterns.
      run_phase(16'h8000, 16'd3, 0, 0, 70);
      run_phase(16'h0000, 16'hA5F0, 69, 0, 70);
      run_phase(16'hFFFF, 16'd15, 0, 69, 30);
      run_phase(16'h1234, 16'h000F, 10, 10, 70);
      run_phase(16'd100, 16'd1, 69, 0, 70);
      run_phase(16'hFFFE, 16'h5A57, 0, 69, 70);
      run_phase(16'h4000, 16'd0, 10, 10, 70);
      write_reg(CSR_UNUSED, 16'hFFFF);
      run_phase(16'd66, 16'd2, 0, 0, 60);

      settle();
      if (errors == 0)
         $display("tb_bright_span_segmenter_core: clean");
      else
         $display("tb_bright_span_segmenter_core: errors");
      $finish;
   end

   // Hard limit on the run length.
   initial begin
      #5_000_000;
      $display("tb_bright_span_segmenter_core: errors");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bss_pkg.sv
hw/rtl/bss_front.sv
hw/rtl/bss_queue.sv
hw/rtl/bss_back.sv
hw/rtl/bright_span_segmenter_core.sv
tb/tb_bright_span_segmenter_core.sv
